@@ rtl/wfdp_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the watermark fifo with drop policy
package wfdp_pkg;

  localparam int ItemFieldW = 64;
  localparam int CfgW       = 11;
  localparam int StatW      = 32;
  localparam int NumCnt     = 6;

  // op field codes
  localparam logic [2:0] OP_PUSH      = 3'd0;
  localparam logic [2:0] OP_TRY_PUSH  = 3'd1;
  localparam logic [2:0] OP_POP       = 3'd2;
  localparam logic [2:0] OP_PEEK      = 3'd3;
  localparam logic [2:0] OP_CANCEL    = 3'd4;
  localparam logic [2:0] OP_CLEAR     = 3'd5;
  localparam logic [2:0] OP_READ_STAT = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_CAPACITY  = 2'd0;
  localparam logic [1:0] REG_HIGH_MARK = 2'd1;
  localparam logic [1:0] REG_LOW_MARK  = 2'd2;
  localparam logic [1:0] REG_POLICY    = 2'd3;

  localparam logic [1:0] POL_DROP_OLDEST = 2'd1;

  // counter slots
  localparam int CNT_ENQ  = 0;
  localparam int CNT_DEQ  = 1;
  localparam int CNT_DROP = 2;
  localparam int CNT_FULL = 3;
  localparam int CNT_HIGH = 4;
  localparam int CNT_LOW  = 5;

  localparam logic [2:0] STAT_PEAK = 3'd6;
  localparam logic [2:0] STAT_MEAN = 3'd7;

  typedef enum logic [2:0] {
    KIND_PUSH,
    KIND_TRY_PUSH,
    KIND_POP,
    KIND_PEEK,
    KIND_CANCEL,
    KIND_CLEAR,
    KIND_READ_STAT,
    KIND_NOP
  } kind_e;

  typedef enum logic [2:0] {
    CLS_NORMAL   = 3'd0,
    CLS_LOW      = 3'd1,
    CLS_HIGH     = 3'd2,
    CLS_FULL     = 3'd3,
    CLS_SHUTDOWN = 3'd4
  } class_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLASSIFY,
    ST_AVERAGE,
    ST_RESULT
  } state_e;

  typedef struct packed {
    logic [2:0]            op;
    logic [ItemFieldW-1:0] item_data;
    logic [2:0]            stat_index;
  } in_word_t;

  typedef struct packed {
    logic                  success;
    logic                  item_valid;
    logic [ItemFieldW-1:0] out_data;
    logic [CfgW-1:0]       depth;
    logic [2:0]            queue_state;
    logic                  state_changed;
    logic [StatW-1:0]      stat_value;
  } out_word_t;

  typedef struct packed {
    kind_e                 kind;
    logic [ItemFieldW-1:0] data;
    logic [2:0]            stat_index;
  } cmd_t;

endpackage

@@ rtl/wfdp_ram.sv @@
`timescale 1ns / 1ps
// generic single write port ram with registered read
module wfdp_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/wfdp_avg.sv @@
`timescale 1ns / 1ps
// three stage update of the q8 mean depth: (9*mean + depth*256) / 10
module wfdp_avg #(
  parameter int CNT_W = 11,
  localparam int MW = CNT_W + 8,
  localparam int XW = MW + 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [CNT_W-1:0] depth_i,
  input  logic [MW-1:0]    mean_i,
  output logic             done_o,
  output logic [MW-1:0]    mean_o
);

  // floor(2^XW / 10), quotient estimate is low by at most one
  localparam longint unsigned Recip = (64'd1 << XW) / 10;

  logic [2:0]      vld_q;
  logic [XW-1:0]   x_q, x_d;
  logic [2*XW-1:0] prod_q, prod_d;
  logic [MW-1:0]   mean_q, mean_d;
  logic [XW-1:0]   quot, rem;

  always_comb begin
    x_d = (XW'(mean_i) << 3) + XW'(mean_i) + (XW'(depth_i) << 8);
    prod_d = (2 * XW)'(x_q) * (2 * XW)'(Recip);
    quot = prod_q[2*XW-1:XW];
    rem = x_q - (quot << 3) - (quot << 1);
    mean_d = (rem >= XW'(10)) ? MW'(quot + XW'(1)) : MW'(quot);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= x_d;
    end
    if (vld_q[0]) begin
      prod_q <= prod_d;
    end
    if (vld_q[1]) begin
      mean_q <= mean_d;
    end
  end

  assign done_o = vld_q[2];
  assign mean_o = mean_q;

endmodule

@@ rtl/wfdp_front.sv @@
`timescale 1ns / 1ps
// front end: accepts words, decodes the op and buffers commands in a two entry queue
module wfdp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wfdp_pkg::in_word_t in_word_i,
  output logic              cmd_valid_o,
  input  logic              cmd_ready_i,
  output wfdp_pkg::cmd_t    cmd_o
);

  wfdp_pkg::cmd_t slot_q [2];
  wfdp_pkg::cmd_t cmd_d;
  logic           wr_q, rd_q;
  logic [1:0]     fill_q;
  logic           push, pop;

  always_comb begin
    cmd_d.data = in_word_i.item_data;
    cmd_d.stat_index = in_word_i.stat_index;
    unique case (in_word_i.op)
      wfdp_pkg::OP_PUSH:      cmd_d.kind = wfdp_pkg::KIND_PUSH;
      wfdp_pkg::OP_TRY_PUSH:  cmd_d.kind = wfdp_pkg::KIND_TRY_PUSH;
      wfdp_pkg::OP_POP:       cmd_d.kind = wfdp_pkg::KIND_POP;
      wfdp_pkg::OP_PEEK:      cmd_d.kind = wfdp_pkg::KIND_PEEK;
      wfdp_pkg::OP_CANCEL:    cmd_d.kind = wfdp_pkg::KIND_CANCEL;
      wfdp_pkg::OP_CLEAR:     cmd_d.kind = wfdp_pkg::KIND_CLEAR;
      wfdp_pkg::OP_READ_STAT: cmd_d.kind = wfdp_pkg::KIND_READ_STAT;
      default:                cmd_d.kind = wfdp_pkg::KIND_NOP;
    endcase
  end

  assign in_ready_o  = (fill_q != 2'd2);
  assign cmd_valid_o = (fill_q != 2'd0);
  assign cmd_o       = slot_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 2'd1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_q] <= cmd_d;
    end
  end

endmodule

@@ rtl/wfdp_back.sv @@
`timescale 1ns / 1ps
// back end: ring control, watermark classification and statistics sequencer
module wfdp_back #(
  parameter int MAX_ENTRIES = 1024,
  parameter int ITEM_BITS = 64,
  localparam int AW = $clog2(MAX_ENTRIES),
  localparam int CW = $clog2(MAX_ENTRIES + 1),
  localparam int CMP_W = (CW > wfdp_pkg::CfgW) ? CW : wfdp_pkg::CfgW,
  localparam int MW = CW + 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  wfdp_pkg::cmd_t       cmd_i,
  input  logic [1:0]           policy_i,
  input  logic [CMP_W-1:0]     eff_cap_i,
  input  logic [CMP_W-1:0]     eff_hi_i,
  input  logic [CMP_W-1:0]     eff_lo_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output wfdp_pkg::out_word_t  out_word_o
);

  wfdp_pkg::state_e state_q, state_d;
  wfdp_pkg::cmd_t   cmd_q;
  wfdp_pkg::class_e class_q, cls_raw, cls_new;

  logic [AW-1:0]    head_q, tail_q;
  logic [CW-1:0]    count_q, count_nx, peak_q, d_q;
  logic             cancel_q;
  logic [31:0]      cnt_q [wfdp_pkg::NumCnt];
  logic [MW-1:0]    mean_q, avg_mean;
  logic             avg_start, avg_done;

  logic             succ_q, ivalid_q, chg_q;
  logic [63:0]      odata_q;
  logic [31:0]      sval_q, sval_sel;

  logic             ram_re, ram_we;
  logic [ITEM_BITS-1:0] rd_data;

  logic full, empty, do_enq, do_evict, bump_drop, bump_full, do_pop, do_peek, do_cls;
  logic [CMP_W-1:0] dw;
  logic [CW+10:0]   depth_ext;

  function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] idx);
    return (idx == AW'(MAX_ENTRIES - 1)) ? '0 : idx + AW'(1);
  endfunction

  // decode of the command held in the exec state
  always_comb begin
    full      = (CMP_W'(count_q) >= eff_cap_i);
    empty     = (count_q == '0);
    do_enq    = 1'b0;
    do_evict  = 1'b0;
    bump_drop = 1'b0;
    bump_full = 1'b0;
    do_pop    = 1'b0;
    do_peek   = 1'b0;
    unique case (cmd_q.kind)
      wfdp_pkg::KIND_PUSH: begin
        if (!cancel_q) begin
          if (!full) begin
            do_enq = 1'b1;
          end else if (policy_i == wfdp_pkg::POL_DROP_OLDEST) begin
            do_enq    = 1'b1;
            do_evict  = !empty;
            bump_drop = !empty;
          end else begin
            bump_drop = 1'b1;
          end
        end
      end
      wfdp_pkg::KIND_TRY_PUSH: begin
        if (!cancel_q) begin
          if (full) begin
            bump_drop = 1'b1;
            bump_full = 1'b1;
          end else begin
            do_enq = 1'b1;
          end
        end
      end
      wfdp_pkg::KIND_POP:  do_pop = !empty;
      wfdp_pkg::KIND_PEEK: do_peek = !empty;
      default: ;
    endcase
    do_cls = do_enq || do_pop;
    if (do_enq && !do_evict) begin
      count_nx = count_q + CW'(1);
    end else if (do_pop) begin
      count_nx = count_q - CW'(1);
    end else begin
      count_nx = count_q;
    end
  end

  // stat readout
  always_comb begin
    priority if (cmd_q.stat_index == wfdp_pkg::STAT_PEAK) begin
      sval_sel = 32'(peak_q);
    end else if (cmd_q.stat_index == wfdp_pkg::STAT_MEAN) begin
      sval_sel = 32'(mean_q);
    end else begin
      sval_sel = cnt_q[cmd_q.stat_index];
    end
  end

  // watermark classification of the latched depth
  always_comb begin
    dw = CMP_W'(d_q);
    priority if (dw >= eff_cap_i) begin
      cls_raw = wfdp_pkg::CLS_FULL;
    end else if (dw >= eff_hi_i) begin
      cls_raw = wfdp_pkg::CLS_HIGH;
    end else if (dw <= eff_lo_i) begin
      cls_raw = wfdp_pkg::CLS_LOW;
    end else begin
      cls_raw = wfdp_pkg::CLS_NORMAL;
    end
    cls_new = cancel_q ? wfdp_pkg::CLS_SHUTDOWN : cls_raw;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wfdp_pkg::ST_IDLE:     if (cmd_valid_i) state_d = wfdp_pkg::ST_EXEC;
      wfdp_pkg::ST_EXEC:     state_d = do_cls ? wfdp_pkg::ST_CLASSIFY : wfdp_pkg::ST_RESULT;
      wfdp_pkg::ST_CLASSIFY: state_d = wfdp_pkg::ST_AVERAGE;
      wfdp_pkg::ST_AVERAGE:  if (avg_done) state_d = wfdp_pkg::ST_RESULT;
      wfdp_pkg::ST_RESULT:   if (out_ready_i) state_d = wfdp_pkg::ST_IDLE;
      default:               state_d = wfdp_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    cmd_ready_o = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    avg_start   = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      wfdp_pkg::ST_IDLE: begin
        cmd_ready_o = 1'b1;
        ram_re      = cmd_valid_i;
      end
      wfdp_pkg::ST_EXEC:     ram_we = do_enq;
      wfdp_pkg::ST_CLASSIFY: avg_start = 1'b1;
      wfdp_pkg::ST_AVERAGE: ;
      wfdp_pkg::ST_RESULT:   out_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= wfdp_pkg::ST_IDLE;
      head_q   <= '0;
      tail_q   <= '0;
      count_q  <= '0;
      cancel_q <= 1'b0;
      class_q  <= wfdp_pkg::CLS_NORMAL;
      cnt_q    <= '{default: '0};
      peak_q   <= '0;
      mean_q   <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        wfdp_pkg::ST_EXEC: begin
          if (do_evict || do_pop) begin
            head_q <= next_slot(head_q);
          end
          if (do_enq) begin
            tail_q <= next_slot(tail_q);
            cnt_q[wfdp_pkg::CNT_ENQ] <= cnt_q[wfdp_pkg::CNT_ENQ] + 32'd1;
            if (count_nx > peak_q) begin
              peak_q <= count_nx;
            end
          end
          count_q <= count_nx;
          if (bump_drop) begin
            cnt_q[wfdp_pkg::CNT_DROP] <= cnt_q[wfdp_pkg::CNT_DROP] + 32'd1;
          end
          if (bump_full) begin
            cnt_q[wfdp_pkg::CNT_FULL] <= cnt_q[wfdp_pkg::CNT_FULL] + 32'd1;
          end
          if (do_pop) begin
            cnt_q[wfdp_pkg::CNT_DEQ] <= cnt_q[wfdp_pkg::CNT_DEQ] + 32'd1;
          end
          if (cmd_q.kind == wfdp_pkg::KIND_CANCEL) begin
            cancel_q <= 1'b1;
          end
          if (cmd_q.kind == wfdp_pkg::KIND_CLEAR) begin
            cnt_q   <= '{default: '0};
            peak_q  <= '0;
            mean_q  <= '0;
            class_q <= wfdp_pkg::CLS_NORMAL;
          end
        end
        wfdp_pkg::ST_CLASSIFY: begin
          class_q <= cls_new;
          unique case (cls_raw)
            wfdp_pkg::CLS_FULL:
              cnt_q[wfdp_pkg::CNT_FULL] <= cnt_q[wfdp_pkg::CNT_FULL] + 32'd1;
            wfdp_pkg::CLS_HIGH:
              cnt_q[wfdp_pkg::CNT_HIGH] <= cnt_q[wfdp_pkg::CNT_HIGH] + 32'd1;
            wfdp_pkg::CLS_LOW:
              cnt_q[wfdp_pkg::CNT_LOW] <= cnt_q[wfdp_pkg::CNT_LOW] + 32'd1;
            default: ;
          endcase
        end
        wfdp_pkg::ST_AVERAGE: begin
          if (avg_done) begin
            mean_q <= avg_mean;
          end
        end
        default: ;
      endcase
    end
  end

  // result and command payload
  always_ff @(posedge clk_i) begin
    if (state_q == wfdp_pkg::ST_IDLE && cmd_valid_i) begin
      cmd_q <= cmd_i;
    end
    if (state_q == wfdp_pkg::ST_EXEC) begin
      succ_q   <= do_enq || do_pop || do_peek;
      ivalid_q <= do_pop || do_peek;
      odata_q  <= (do_pop || do_peek) ? 64'(rd_data) : 64'd0;
      chg_q    <= 1'b0;
      sval_q   <= (cmd_q.kind == wfdp_pkg::KIND_READ_STAT) ? sval_sel : 32'd0;
      d_q      <= count_nx;
    end
    if (state_q == wfdp_pkg::ST_CLASSIFY) begin
      chg_q <= (cls_new != class_q);
    end
  end

  assign depth_ext = {11'b0, count_q};

  always_comb begin
    out_word_o.success       = succ_q;
    out_word_o.item_valid    = ivalid_q;
    out_word_o.out_data      = odata_q;
    out_word_o.depth         = depth_ext[10:0];
    out_word_o.queue_state   = class_q;
    out_word_o.state_changed = chg_q;
    out_word_o.stat_value    = sval_q;
  end

  wfdp_ram #(
    .WIDTH (ITEM_BITS),
    .DEPTH (MAX_ENTRIES)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (cmd_q.data[ITEM_BITS-1:0]),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (rd_data)
  );

  wfdp_avg #(
    .CNT_W (CW)
  ) u_avg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (avg_start),
    .depth_i (d_q),
    .mean_i  (mean_q),
    .done_o  (avg_done),
    .mean_o  (avg_mean)
  );

endmodule

@@ rtl/watermark_fifo_with_drop_policy_top.sv @@
`timescale 1ns / 1ps
// top level: config registers, effective watermarks, front and back ends
// sequence: the back end takes a command only in idle, then steps exec and result for ops
//   that neither enqueue nor pop; an enqueue or a pop also passes classify and average
// the back end takes no new command until its result is taken and it is back in idle;
//   meanwhile the front queue holds 2 words; the mean update has three stages
// reset: control, pointers and counters cleared, config set to its defaults, all
//   asynchronously; ring ram not cleared
module watermark_fifo_with_drop_policy_top #(
  parameter int MAX_ENTRIES = 1024,
  parameter int ITEM_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  wfdp_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output wfdp_pkg::out_word_t out_word_o,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_index_i,
  input  logic [10:0]         cfg_wdata_i
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int CmpW = (CW > wfdp_pkg::CfgW) ? CW : wfdp_pkg::CfgW;

  logic [10:0]     cap_q, high_q, low_q;
  logic [1:0]      policy_q;
  logic [CmpW-1:0] eff_cap_q, eff_cap_d, eff_hi_q, eff_hi_d, eff_lo_q, eff_lo_d;
  logic [CmpW+1:0] cap3;
  logic            cmd_valid, cmd_ready;
  wfdp_pkg::cmd_t  cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q    <= 11'd1024;
      high_q   <= 11'd768;
      low_q    <= 11'd256;
      policy_q <= 2'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        wfdp_pkg::REG_CAPACITY:  cap_q <= cfg_wdata_i;
        wfdp_pkg::REG_HIGH_MARK: high_q <= cfg_wdata_i;
        wfdp_pkg::REG_LOW_MARK:  low_q <= cfg_wdata_i;
        wfdp_pkg::REG_POLICY:    policy_q <= cfg_wdata_i[1:0];
        default: ;
      endcase
    end
  end

  // capacity clamp and high mark in one stage, low mark in the next
  always_comb begin
    if (cap_q == 11'd0) begin
      eff_cap_d = CmpW'(1);
    end else if (CmpW'(cap_q) > CmpW'(MAX_ENTRIES)) begin
      eff_cap_d = CmpW'(MAX_ENTRIES);
    end else begin
      eff_cap_d = CmpW'(cap_q);
    end
    cap3 = {2'b00, eff_cap_d} + {1'b0, eff_cap_d, 1'b0};
    eff_hi_d = (CmpW'(high_q) >= eff_cap_d) ? cap3[CmpW+1:2] : CmpW'(high_q);
    eff_lo_d = (CmpW'(low_q) >= eff_hi_q) ? (eff_cap_q >> 2) : CmpW'(low_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      eff_cap_q <= CmpW'(1);
      eff_hi_q  <= '0;
      eff_lo_q  <= '0;
    end else begin
      eff_cap_q <= eff_cap_d;
      eff_hi_q  <= eff_hi_d;
      eff_lo_q  <= eff_lo_d;
    end
  end

  wfdp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  wfdp_back #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .ITEM_BITS   (ITEM_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .policy_i    (policy_q),
    .eff_cap_i   (eff_cap_q),
    .eff_hi_i    (eff_hi_q),
    .eff_lo_i    (eff_lo_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

  a_item_implies_success: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.item_valid |-> out_word_o.success)
    else $error("item returned without success");

  a_stat_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.stat_value != 32'd0) |-> !out_word_o.success)
    else $error("stat value on a queue operation");

  a_high_below_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eff_hi_q < eff_cap_q)
    else $error("effective high mark not below capacity");

endmodule
